[hdl/bbc_pkg.sv]
// Shared types, codes and helpers of the block buffer cache.
package bbc_pkg;

   localparam int NUM_BUFFERS_DEFAULT = 32;

   localparam logic [7:0]  COUNT_MAX = 8'hFF;
   localparam logic [31:0] TIME_NONE = 32'hFFFF_FFFF;

   localparam logic [1:0] MODE_GET     = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_PIN     = 2'd2;
   localparam logic [1:0] MODE_UNPIN   = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_BUFFER  = 2'd1;
   localparam logic [1:0] STATUS_COUNT_ZERO = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  device;
      logic [31:0] block_number;
      logic [4:0]  buffer_index;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [4:0] slot;
      logic       hit;
      logic       needs_read;
      logic [7:0] count_after;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  device;
      logic [31:0] block;
      logic        valid;
      logic [7:0]  count;
      logic [31:0] release_time;
   } entry_type;

   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_SCAN_LAST,
      STATE_COMMIT,
      STATE_ONE_READ,
      STATE_ONE_MOD
   } state_type;

   function automatic logic [7:0] raise_count(input logic [7:0] c);
      return (c == COUNT_MAX) ? COUNT_MAX : c + 8'd1;
   endfunction

endpackage

[hdl/block_buffer_cache_lru.sv]
// Top level of the block buffer cache: tag table, reference counts, LRU victim choice.
//
//  channel  dir  handshake              word
//  -------  ---  ---------------------  ---------------------------------------
//  req      in   req_valid / req_ready  mode, device, block_number, index, now
//  rsp      out  rsp_valid / rsp_ready  slot, hit, needs_read, count_after, status
//
//  A get walks the whole table through the single read port of the entry
//  memory, one entry per cycle, and takes no new request until it is done.
//  Release, pin and unpin read one entry and write it back.
//  Reset is synchronous; a per-entry written bit makes untouched entries read
//  as zero, so no clearing pass is needed and requests are taken right away.
//  A stalled rsp holds the finished item in its register; the next request
//  still runs and waits only at its write-back step until the register frees.
module block_buffer_cache_lru #(
   parameter int NUM_BUFFERS = bbc_pkg::NUM_BUFFERS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bbc_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bbc_pkg::rsp_type rsp_word
);

   localparam int AW = $clog2(NUM_BUFFERS);

   // entry memory, one read and one write port, registered read
   bbc_pkg::entry_type mem [NUM_BUFFERS];
   logic [NUM_BUFFERS-1:0] written_ff;
   bbc_pkg::entry_type rd_entry_ff;
   logic               rd_written_ff;
   bbc_pkg::entry_type ent;

   bbc_pkg::state_type state_ff, state_in;
   bbc_pkg::req_type   req_ff;

   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] wr_addr;
   bbc_pkg::entry_type wr_entry;

   // scan walker and its compare stage
   logic [AW-1:0] scan_addr_ff;
   logic          chk_valid_ff;
   logic [AW-1:0] chk_idx_ff;

   // running results of the scan
   logic               match_found_ff;
   logic [AW-1:0]      match_idx_ff;
   bbc_pkg::entry_type match_entry_ff;
   logic               victim_found_ff;
   logic [AW-1:0]      victim_idx_ff;
   logic [31:0]        victim_time_ff;

   // result register
   logic             rsp_valid_ff;
   bbc_pkg::rsp_type rsp_ff;
   logic             rsp_load;
   bbc_pkg::rsp_type rsp_in;

   logic          accept;
   logic          can_emit;
   logic          idx_in_range;
   logic [AW-1:0] idx_addr;
   logic [7:0]    cnt_dec;

   assign req_ready    = (state_ff == bbc_pkg::STATE_IDLE);
   assign accept       = req_valid && req_ready;
   assign can_emit     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_ff;

   // an index beyond the table touches nothing; clamp its read address
   assign idx_in_range = (32'(req_ff.buffer_index) < NUM_BUFFERS);
   assign idx_addr     = idx_in_range ? AW'(req_ff.buffer_index) : '0;

   // an entry never written reads as its reset value
   assign ent     = rd_written_ff ? rd_entry_ff : '0;
   assign cnt_dec = ent.count - 8'd1;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff   <= mem[rd_addr];
      rd_written_ff <= written_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (mem_we) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbc_pkg::STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state, memory access and result word
   always_comb begin
      state_in = state_ff;
      rd_addr  = '0;
      mem_we   = 1'b0;
      wr_addr  = idx_addr;
      wr_entry = ent;
      rsp_load = 1'b0;
      rsp_in   = '0;
      unique case (state_ff)
         bbc_pkg::STATE_IDLE: begin
            if (accept) begin
               state_in = (req_word.mode == bbc_pkg::MODE_GET) ?
                          bbc_pkg::STATE_SCAN : bbc_pkg::STATE_ONE_READ;
            end
         end
         bbc_pkg::STATE_SCAN: begin
            rd_addr = scan_addr_ff;
            if (scan_addr_ff == AW'(NUM_BUFFERS - 1)) begin
               state_in = bbc_pkg::STATE_SCAN_LAST;
            end
         end
         bbc_pkg::STATE_SCAN_LAST: begin
            state_in = bbc_pkg::STATE_COMMIT;
         end
         bbc_pkg::STATE_COMMIT: begin
            if (can_emit) begin
               state_in = bbc_pkg::STATE_IDLE;
               rsp_load = 1'b1;
               priority if (match_found_ff) begin
                  // hit: raise the count, mark valid, report a read if it was not
                  mem_we         = 1'b1;
                  wr_addr        = match_idx_ff;
                  wr_entry       = match_entry_ff;
                  wr_entry.count = bbc_pkg::raise_count(match_entry_ff.count);
                  wr_entry.valid = 1'b1;
                  rsp_in.slot        = 5'(match_idx_ff);
                  rsp_in.hit         = 1'b1;
                  rsp_in.needs_read  = !match_entry_ff.valid;
                  rsp_in.count_after = bbc_pkg::raise_count(match_entry_ff.count);
                  rsp_in.status      = bbc_pkg::STATUS_OK;
               end else if (victim_found_ff) begin
                  // miss: retag the oldest released entry, keep its stamp
                  mem_we                = 1'b1;
                  wr_addr               = victim_idx_ff;
                  wr_entry.device       = req_ff.device;
                  wr_entry.block        = req_ff.block_number;
                  wr_entry.valid        = 1'b1;
                  wr_entry.count        = 8'd1;
                  wr_entry.release_time = victim_time_ff;
                  rsp_in.slot        = 5'(victim_idx_ff);
                  rsp_in.needs_read  = 1'b1;
                  rsp_in.count_after = 8'd1;
                  rsp_in.status      = bbc_pkg::STATUS_OK;
               end else begin
                  rsp_in.status = bbc_pkg::STATUS_NO_BUFFER;
               end
            end
         end
         bbc_pkg::STATE_ONE_READ: begin
            rd_addr  = idx_addr;
            state_in = bbc_pkg::STATE_ONE_MOD;
         end
         bbc_pkg::STATE_ONE_MOD: begin
            // keep the address so the read data holds through a stall
            rd_addr = idx_addr;
            if (can_emit) begin
               state_in    = bbc_pkg::STATE_IDLE;
               rsp_load    = 1'b1;
               rsp_in.slot = req_ff.buffer_index;
               if (!idx_in_range) begin
                  rsp_in.status = bbc_pkg::STATUS_COUNT_ZERO;
               end else begin
                  unique case (req_ff.mode)
                     bbc_pkg::MODE_PIN: begin
                        mem_we             = 1'b1;
                        wr_entry.count     = bbc_pkg::raise_count(ent.count);
                        rsp_in.count_after = bbc_pkg::raise_count(ent.count);
                     end
                     bbc_pkg::MODE_RELEASE, bbc_pkg::MODE_UNPIN: begin
                        if (ent.count == 8'd0) begin
                           rsp_in.status = bbc_pkg::STATUS_COUNT_ZERO;
                        end else begin
                           mem_we             = 1'b1;
                           wr_entry.count     = cnt_dec;
                           rsp_in.count_after = cnt_dec;
                           // stamp the final release
                           if (req_ff.mode == bbc_pkg::MODE_RELEASE && cnt_dec == 8'd0) begin
                              wr_entry.release_time = req_ff.now;
                           end
                        end
                     end
                     bbc_pkg::MODE_GET: begin
                        rsp_in.status = bbc_pkg::STATUS_OK;
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = bbc_pkg::STATE_IDLE;
         end
      endcase
   end

   // request latch, scan walker and scan accumulators
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
      end
      if (state_ff == bbc_pkg::STATE_SCAN) begin
         scan_addr_ff <= scan_addr_ff + AW'(1);
      end else begin
         scan_addr_ff <= '0;
      end
      chk_idx_ff <= scan_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff    <= 1'b0;
         match_found_ff  <= 1'b0;
         victim_found_ff <= 1'b0;
      end else begin
         chk_valid_ff <= (state_ff == bbc_pkg::STATE_SCAN);
         if (accept) begin
            match_found_ff  <= 1'b0;
            victim_found_ff <= 1'b0;
         end else if (chk_valid_ff) begin
            // first tag match wins, valid bit ignored
            if (!match_found_ff && ent.device == req_ff.device &&
                ent.block == req_ff.block_number) begin
               match_found_ff <= 1'b1;
            end
            // oldest unreferenced entry, lowest index on a tie
            if (ent.count == 8'd0 &&
                (!victim_found_ff || ent.release_time < victim_time_ff)) begin
               victim_found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         victim_time_ff <= bbc_pkg::TIME_NONE;
      end else if (chk_valid_ff) begin
         if (!match_found_ff && ent.device == req_ff.device &&
             ent.block == req_ff.block_number) begin
            match_idx_ff   <= chk_idx_ff;
            match_entry_ff <= ent;
         end
         if (ent.count == 8'd0 &&
             (!victim_found_ff || ent.release_time < victim_time_ff)) begin
            victim_idx_ff  <= chk_idx_ff;
            victim_time_ff <= ent.release_time;
         end
      end
   end

   // result register: load a finished word, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[hdl/bbc_checker.sv]
// Port-level checks of the block buffer cache and their bind to the top level.
module bbc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bbc_pkg::req_type req_word,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bbc_pkg::rsp_type rsp_word
);

   // a held result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // one request at a time: busy right after taking a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a full table reports an empty word
   a_no_buffer_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == bbc_pkg::STATUS_NO_BUFFER |->
      rsp_word.slot == 5'd0 && !rsp_word.hit && !rsp_word.needs_read &&
      rsp_word.count_after == 8'd0)
      else $error("no-buffer word carries data");

   // a hit succeeds and leaves the entry referenced
   a_hit_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.hit |->
      rsp_word.status == bbc_pkg::STATUS_OK && rsp_word.count_after != 8'd0)
      else $error("hit without a reference");

   // a fresh allocation starts at one reference
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.hit && rsp_word.needs_read |->
      rsp_word.count_after == 8'd1 && rsp_word.status == bbc_pkg::STATUS_OK)
      else $error("allocation with wrong count");

endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (.*);

[sim/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the block buffer cache with LRU replacement.
module tb;

   localparam int NB = bbc_pkg::NUM_BUFFERS_DEFAULT;
   localparam int RAND_ITEMS = 300;
   localparam int CALM_ITEMS = 100;      // tail of the random part with no idling
   localparam int TAIL_CYCLES = NB + 8;  // one full get walk plus margin
   localparam int LIMIT_CYCLES = 400000;

   typedef struct {
      bbc_pkg::req_type word;
      int unsigned      reps;
      bit               sweep;  // step buffer_index and block_number per repeat
      bit               typed;  // expectation written into the row
      bbc_pkg::rsp_type want;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   bbc_pkg::req_type req_word = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   bbc_pkg::rsp_type rsp_word;

   // Shadow of the tag table, advanced at each accepted request word.
   logic [7:0]  dev_tag   [NB];
   logic [31:0] blk_tag   [NB];
   logic        loaded    [NB];
   logic [7:0]  refs      [NB];
   logic [31:0] stamp     [NB];

   bbc_pkg::rsp_type owed_rsp_q[$];   // replies the cache still owes, oldest first
   stim_row_type     plan[$];

   int          cycles = 0;
   int          stall_left = 0;
   int          fail_count = 0;
   bit          calm = 1'b0;
   logic [31:0] tick = 32'd0;

   int          n_words = 0;
   int          n_hits = 0;
   int          n_allocs = 0;
   int          n_nobuf = 0;
   int          n_zero = 0;
   int          n_ceiling = 0;

   wire quiet_window = (cycles[7:6] == 2'b00);

   block_buffer_cache_lru dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Saturating count increment shared by get-hit and pin.
   function automatic logic [7:0] bump(input logic [7:0] c);
      return (c == bbc_pkg::COUNT_MAX) ? bbc_pkg::COUNT_MAX : c + 8'd1;
   endfunction

   // Apply one request word to the shadow table and return the reply it earns.
   function automatic bbc_pkg::rsp_type apply_buffer_op(input bbc_pkg::req_type w);
      bbc_pkg::rsp_type r;
      int               i;
      int               found;
      int               victim;
      logic [31:0]      oldest;
      r = '0;
      r.slot = w.buffer_index;
      r.status = bbc_pkg::STATUS_OK;
      if (w.mode == bbc_pkg::MODE_GET) begin
         r.slot = '0;
         found = -1;
         // Compare every entry, valid or not; the lowest matching index wins.
         for (i = 0; i < NB; i++) begin
            if (found < 0 && dev_tag[i] == w.device && blk_tag[i] == w.block_number)
               found = i;
         end
         if (found >= 0) begin
            refs[found] = bump(refs[found]);
            r.slot = found[4:0];
            r.hit = 1'b1;
            r.needs_read = !loaded[found];
            r.count_after = refs[found];
            loaded[found] = 1'b1;
            return r;
         end
         // Take the unreferenced entry released longest ago; ties go low.
         victim = -1;
         oldest = bbc_pkg::TIME_NONE;
         for (i = 0; i < NB; i++) begin
            if (refs[i] == 8'd0 && (victim < 0 || stamp[i] < oldest)) begin
               victim = i;
               oldest = stamp[i];
            end
         end
         if (victim < 0) begin
            r.status = bbc_pkg::STATUS_NO_BUFFER;
            return r;
         end
         dev_tag[victim] = w.device;
         blk_tag[victim] = w.block_number;
         refs[victim] = 8'd1;
         loaded[victim] = 1'b1;
         r.slot = victim[4:0];
         r.needs_read = 1'b1;
         r.count_after = 8'd1;
         return r;
      end
      if (int'(w.buffer_index) >= NB) begin
         r.status = bbc_pkg::STATUS_COUNT_ZERO;
         return r;
      end
      if (w.mode == bbc_pkg::MODE_PIN) begin
         refs[w.buffer_index] = bump(refs[w.buffer_index]);
         r.count_after = refs[w.buffer_index];
         return r;
      end
      if (refs[w.buffer_index] == 8'd0) begin
         r.status = bbc_pkg::STATUS_COUNT_ZERO;
         return r;
      end
      refs[w.buffer_index] = refs[w.buffer_index] - 8'd1;
      // Only the final release stamps the time; unpin never does.
      if (w.mode == bbc_pkg::MODE_RELEASE && refs[w.buffer_index] == 8'd0)
         stamp[w.buffer_index] = w.now;
      r.count_after = refs[w.buffer_index];
      return r;
   endfunction

   function automatic stim_row_type row_of(input logic [1:0] m, input logic [7:0] d,
                                           input logic [31:0] b, input logic [4:0] i,
                                           input logic [31:0] t, input int unsigned reps,
                                           input bit sweep);
      stim_row_type s;
      s.word.mode = m;
      s.word.device = d;
      s.word.block_number = b;
      s.word.buffer_index = i;
      s.word.now = t;
      s.reps = reps;
      s.sweep = sweep;
      s.typed = 1'b0;
      s.want = '0;
      return s;
   endfunction

   function automatic stim_row_type row_want(input logic [1:0] m, input logic [7:0] d,
                                             input logic [31:0] b, input logic [4:0] i,
                                             input logic [31:0] t, input logic [4:0] slot,
                                             input logic hit, input logic rd,
                                             input logic [7:0] cnt, input logic [1:0] st);
      stim_row_type s;
      s = row_of(m, d, b, i, t, 1, 1'b0);
      s.typed = 1'b1;
      s.want.slot = slot;
      s.want.hit = hit;
      s.want.needs_read = rd;
      s.want.count_after = cnt;
      s.want.status = st;
      return s;
   endfunction

   // Present one word, hold it until taken, log its reply, then maybe idle.
   task automatic issue(input bbc_pkg::req_type w, input bit typed,
                        input bbc_pkg::rsp_type want);
      bbc_pkg::rsp_type r;
      int               gap;
      req_word <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      r = apply_buffer_op(w);
      owed_rsp_q.push_back(typed ? want : r);
      if (!calm && !quiet_window && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Build a random word: mostly a small tag pool so gets hit and evict often,
   // and count updates aimed mostly at entries that are in use.
   function automatic bbc_pkg::req_type random_word();
      bbc_pkg::req_type w;
      int               pick;
      int               i;
      int               live[$];
      pick = $urandom_range(0, 99);
      w.mode = (pick < 40) ? bbc_pkg::MODE_GET :
               (pick < 70) ? bbc_pkg::MODE_RELEASE :
               (pick < 85) ? bbc_pkg::MODE_PIN : bbc_pkg::MODE_UNPIN;
      w.device = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 85)
         w.block_number = $urandom_range(0, 15);
      else if (pick < 90)
         w.block_number = bbc_pkg::TIME_NONE - $urandom_range(0, 3);
      else
         w.block_number = $urandom;
      for (i = 0; i < NB; i++)
         if (refs[i] != 8'd0) live.push_back(i);
      if (live.size() != 0 && $urandom_range(0, 99) < 75)
         w.buffer_index = 5'(live[$urandom_range(0, live.size() - 1)]);
      else
         w.buffer_index = 5'($urandom_range(0, NB - 1));
      tick = tick + $urandom_range(0, 5);
      w.now = ($urandom_range(0, 9) == 0) ? $urandom : tick;
      return w;
   endfunction

   // Receiver: drop ready for short bursts, outside quiet windows and the tail.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && !quiet_window && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check every reply word against the oldest one owed.
   always @(posedge clock) begin
      bbc_pkg::rsp_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_rsp_q.size() == 0) begin
            $display("%0t: reply word with none owed: got %h", $time, rsp_word);
            fail_count++;
         end else begin
            exp = owed_rsp_q.pop_front();
            n_words++;
            if (exp.hit) n_hits++;
            if (!exp.hit && exp.needs_read) n_allocs++;
            if (exp.status == bbc_pkg::STATUS_NO_BUFFER) n_nobuf++;
            if (exp.status == bbc_pkg::STATUS_COUNT_ZERO) n_zero++;
            if (exp.count_after == bbc_pkg::COUNT_MAX) n_ceiling++;
            if (rsp_word.slot !== exp.slot) begin
               $display("%0t: slot expected %0d got %0d", $time, exp.slot, rsp_word.slot);
               fail_count++;
            end
            if (rsp_word.hit !== exp.hit) begin
               $display("%0t: hit expected %0d got %0d", $time, exp.hit, rsp_word.hit);
               fail_count++;
            end
            if (rsp_word.needs_read !== exp.needs_read) begin
               $display("%0t: needs_read expected %0d got %0d", $time,
                        exp.needs_read, rsp_word.needs_read);
               fail_count++;
            end
            if (rsp_word.count_after !== exp.count_after) begin
               $display("%0t: count_after expected %0d got %0d", $time,
                        exp.count_after, rsp_word.count_after);
               fail_count++;
            end
            if (rsp_word.status !== exp.status) begin
               $display("%0t: status expected %0d got %0d", $time,
                        exp.status, rsp_word.status);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on a cycle count well above the slowest correct run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d reply words still owed", $time, owed_rsp_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int               r;
      int               k;
      bbc_pkg::req_type w;

      for (k = 0; k < NB; k++) begin
         dev_tag[k] = '0;
         blk_tag[k] = '0;
         loaded[k] = 1'b0;
         refs[k] = '0;
         stamp[k] = '0;
      end

      // Directed table. Reset leaves every tag at device 0 block 0, so the
      // first get hits entry 0 and still needs a read.
      plan.push_back(row_want(bbc_pkg::MODE_GET, 8'd0, 32'd0, 5'd0, 32'd0,
                              5'd0, 1'b1, 1'b1, 8'd1, bbc_pkg::STATUS_OK));
      plan.push_back(row_want(bbc_pkg::MODE_GET, 8'd0, 32'd0, 5'd0, 32'd0,
                              5'd0, 1'b1, 1'b0, 8'd2, bbc_pkg::STATUS_OK));
      plan.push_back(row_want(bbc_pkg::MODE_RELEASE, 8'd0, 32'd0, 5'd7, 32'd0,
                              5'd7, 1'b0, 1'b0, 8'd0, bbc_pkg::STATUS_COUNT_ZERO));
      plan.push_back(row_want(bbc_pkg::MODE_UNPIN, 8'd0, 32'd0, 5'd31, bbc_pkg::TIME_NONE,
                              5'd31, 1'b0, 1'b0, 8'd0, bbc_pkg::STATUS_COUNT_ZERO));
      // Miss with extreme tags, then pin the new entry past the count ceiling.
      plan.push_back(row_of(bbc_pkg::MODE_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'd0,
                            1, 1'b0));
      plan.push_back(row_of(bbc_pkg::MODE_PIN, 8'd0, 32'd0, 5'd1, 32'd0, 300, 1'b0));
      plan.push_back(row_want(bbc_pkg::MODE_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'd0,
                              5'd1, 1'b1, 1'b0, 8'd255, bbc_pkg::STATUS_OK));
      plan.push_back(row_of(bbc_pkg::MODE_RELEASE, 8'd0, 32'd0, 5'd1, 32'd100, 1, 1'b0));
      // Pin every entry, so a fresh tag finds no free buffer.
      plan.push_back(row_of(bbc_pkg::MODE_PIN, 8'd0, 32'd0, 5'd0, 32'd0, NB, 1'b1));
      plan.push_back(row_want(bbc_pkg::MODE_GET, 8'd3, 32'd12345, 5'd0, 32'd0,
                              5'd0, 1'b0, 1'b0, 8'd0, bbc_pkg::STATUS_NO_BUFFER));
      // Free one entry by unpin (time stays 0) and one by release at all ones.
      plan.push_back(row_of(bbc_pkg::MODE_UNPIN, 8'd0, 32'd0, 5'd4, 32'd77, 1, 1'b0));
      plan.push_back(row_of(bbc_pkg::MODE_RELEASE, 8'd0, 32'd0, 5'd9, bbc_pkg::TIME_NONE,
                            1, 1'b0));
      plan.push_back(row_of(bbc_pkg::MODE_GET, 8'd3, 32'd12345, 5'd0, 32'd0, 1, 1'b0));
      plan.push_back(row_of(bbc_pkg::MODE_GET, 8'd3, 32'd99, 5'd0, 32'd0, 1, 1'b0));
      // Equal release times: the lower index is the victim.
      plan.push_back(row_of(bbc_pkg::MODE_RELEASE, 8'd0, 32'd0, 5'd2, 32'd5, 1, 1'b0));
      plan.push_back(row_of(bbc_pkg::MODE_RELEASE, 8'd0, 32'd0, 5'd3, 32'd5, 1, 1'b0));
      plan.push_back(row_of(bbc_pkg::MODE_GET, 8'd7, 32'd1, 5'd0, 32'd0, 1, 1'b0));
      plan.push_back(row_of(bbc_pkg::MODE_GET, 8'd0, 32'd0, 5'd0, 32'd0, 1, 1'b0));
      plan.push_back(row_of(bbc_pkg::MODE_PIN, 8'd0, 32'd0, 5'd31, 32'd0, 1, 1'b0));
      plan.push_back(row_of(bbc_pkg::MODE_UNPIN, 8'd0, 32'd0, 5'd31, 32'd0, 1, 1'b0));
      plan.push_back(row_of(bbc_pkg::MODE_RELEASE, 8'd0, 32'd0, 5'd31, 32'd0, 1, 1'b0));
      plan.push_back(row_of(bbc_pkg::MODE_GET, 8'd3, 32'd12345, 5'd0, 32'd0, 1, 1'b0));
      plan.push_back(row_of(bbc_pkg::MODE_RELEASE, 8'd0, 32'd0, 5'd0, bbc_pkg::TIME_NONE,
                            1, 1'b0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[p]) begin
         for (r = 0; r < int'(plan[p].reps); r++) begin
            w = plan[p].word;
            if (plan[p].sweep) begin
               w.buffer_index = w.buffer_index + 5'(r);
               w.block_number = w.block_number + r;
            end
            issue(w, plan[p].typed, plan[p].want);
         end
      end

      for (k = 0; k < RAND_ITEMS; k++) begin
         calm = (k >= RAND_ITEMS - CALM_ITEMS);
         issue(random_word(), 1'b0, '0);
         // Hold off once midway until every reply has come back.
         if (k == RAND_ITEMS / 2) begin
            req_valid <= 1'b0;
            while (owed_rsp_q.size() != 0) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      while (owed_rsp_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("checked %0d reply words: %0d get hits, %0d allocations, %0d with no free buffer",
               n_words, n_hits, n_allocs, n_nobuf);
      $display("%0d refusals on a zero count, %0d at the count ceiling, %0d mismatches",
               n_zero, n_ceiling, fail_count);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
